// ----- design/ssa_pkg.sv -----
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared codes and controller/datapath interface types of the segmented stack
// allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

   // request operations
   localparam logic [2:0] OP_INIT     = 3'd0;
   localparam logic [2:0] OP_ALLOC    = 3'd1;
   localparam logic [2:0] OP_FREE_SEG = 3'd2;
   localparam logic [2:0] OP_FREE_STK = 3'd3;
   localparam logic [2:0] OP_SIZE     = 3'd4;

   // response status
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTHING  = 2'd2;
   localparam logic [1:0] ST_INACTIVE = 2'd3;

   // datapath actions issued by the controller
   localparam logic [4:0] ACT_NONE       = 5'd0;
   localparam logic [4:0] ACT_LOAD       = 5'd1;
   localparam logic [4:0] ACT_NOTHING    = 5'd2;
   localparam logic [4:0] ACT_INACTIVE   = 5'd3;
   localparam logic [4:0] ACT_EMPTY      = 5'd4;
   localparam logic [4:0] ACT_RD_HEAD    = 5'd5;
   localparam logic [4:0] ACT_RD_TOP     = 5'd6;
   localparam logic [4:0] ACT_POP        = 5'd7;
   localparam logic [4:0] ACT_UNLINK     = 5'd8;
   localparam logic [4:0] ACT_WALK_START = 5'd9;
   localparam logic [4:0] ACT_WALK_RD    = 5'd10;
   localparam logic [4:0] ACT_WALK_WR    = 5'd11;
   localparam logic [4:0] ACT_WALK_END   = 5'd12;
   localparam logic [4:0] ACT_MUL        = 5'd13;
   localparam logic [4:0] ACT_SIZE       = 5'd14;
   localparam logic [4:0] ACT_EMIT       = 5'd15;
   localparam logic [4:0] ACT_CLEAR      = 5'd16;

   typedef struct packed {
      logic [4:0] act;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       op_ok;
      logic       id_ok;
      logic       active;
      logic       head_null;
      logic       walk_done;
      logic       out_free;
      logic       clear_last;
   } stat_type;

endpackage

// ----- design/segmented_stack_allocator.sv -----
// ----------------------------------------------------------------------------
// segmented_stack_allocator
// One request at a time: a new request is taken only once the last response
// is loaded into the output register, which waits while that register is full.
// Init, allocate, free segment and size query pass decode and one link memory
// or multiply step; rejected requests go straight from decode to the response.
// Free stack does one link memory read and one write per segment. After reset
// the link memory is chained while no request is taken.
// ----------------------------------------------------------------------------
module segmented_stack_allocator import ssa_pkg::*; #(
   parameter int NUM_SEGMENTS  = 64,
   parameter int SEGMENT_SLOTS = 1024,
   parameter int NUM_STACKS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [1:0] stack_id, [11:2] top_offset, [15:12] zero
   input  logic [2:0]  req_tuser,  // [2:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [5:0] segment, [15:6] new_top_offset,
                                   // [31:16] element_count
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   // Controller and datapath talk only through these two bundles: the
   // controller issues one action a cycle, the datapath reports flags.
   cmd_type  cmd;
   stat_type stat;

   ssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath holds the free list head, per-stack top/count/active tables,
   // the segment link memory, the size multiplier and the response register.
   ssa_dp #(
      .NUM_SEGMENTS  (NUM_SEGMENTS),
      .SEGMENT_SLOTS (SEGMENT_SLOTS),
      .NUM_STACKS    (NUM_STACKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   // No request may be taken while the link memory is still being chained.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.act == ACT_CLEAR |-> !req_tready)
      else $error("request accepted during link clearing");

   // A request transfer makes the block busy on the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken back to back");

   // Loading the response always presents it on the next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.act == ACT_EMIT |=> rsp_tvalid)
      else $error("response load lost");

   // Reset leaves no stale response.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

// ----- design/ssa_ram.sv -----
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- design/ssa_dp.sv -----
// ----------------------------------------------------------------------------
// ssa_dp
// Datapath: request capture, free list head, per-stack tables, link memory,
// size arithmetic and the response register.
// ----------------------------------------------------------------------------
module ssa_dp import ssa_pkg::*; #(
   parameter int NUM_SEGMENTS  = 64,
   parameter int SEGMENT_SLOTS = 1024,
   parameter int NUM_STACKS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   input  cmd_type     cmd,
   output stat_type    stat
);

   localparam int SEG_W  = $clog2(NUM_SEGMENTS);
   localparam int LINK_W = $clog2(NUM_SEGMENTS + 1);
   localparam int CNT_W  = LINK_W;
   localparam int ID_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int PROD_W = CNT_W + 16;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic [LINK_W-1:0] SEG_NULL = LINK_W'(NUM_SEGMENTS);
   localparam logic [15:0]       SLOT_MAX = 16'(SEGMENT_SLOTS - 1);
   localparam logic [SEG_W-1:0]  CLR_LAST = SEG_W'(NUM_SEGMENTS - 1);
   localparam logic [CNT_W-1:0]  WALK_MAX = CNT_W'(NUM_SEGMENTS);

   // request
   logic [2:0]  op_ff, op_in;
   logic [1:0]  id_ff, id_in;
   logic [9:0]  off_ff, off_in;
   // allocator state
   logic [LINK_W-1:0] head_ff, head_in;
   logic              active_ff [NUM_STACKS];
   logic              active_in [NUM_STACKS];
   logic [SEG_W-1:0]  top_ff [NUM_STACKS];
   logic [SEG_W-1:0]  top_in [NUM_STACKS];
   logic [CNT_W-1:0]  count_ff [NUM_STACKS];
   logic [CNT_W-1:0]  count_in [NUM_STACKS];
   logic [SEG_W-1:0]  clr_ff, clr_in;
   // walk and arithmetic
   logic [LINK_W-1:0] walk_ff, walk_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   // staged result and response register
   logic [1:0]  res_status_ff, res_status_in;
   logic [5:0]  res_seg_ff, res_seg_in;
   logic [9:0]  res_off_ff, res_off_in;
   logic [15:0] res_cnt_ff, res_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_seg_ff, rsp_seg_in;
   logic [9:0]  rsp_off_ff, rsp_off_in;
   logic [15:0] rsp_cnt_ff, rsp_cnt_in;

   // link memory
   logic              ram_wr_en, ram_rd_en;
   logic [SEG_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [LINK_W-1:0] ram_wr_data, ram_rd_data;

   logic [ID_W-1:0]   idx;
   logic              id_ok, cur_active, off_over;
   logic [SEG_W-1:0]  cur_top;
   logic [CNT_W-1:0]  cur_count, mul_a;
   logic [9:0]        off_clamp;
   logic [SUM_W-1:0]  sum;
   logic [15:0]       cnt_sat;
   logic [LINK_W-1:0] head_pop;

   ssa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SEGMENTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign idx        = ID_W'(id_ff);
   assign id_ok      = (32'(id_ff) < NUM_STACKS);
   assign cur_active = id_ok && active_ff[idx];
   assign cur_top    = top_ff[idx];
   assign cur_count  = count_ff[idx];
   assign off_over   = (17'(off_ff) > 17'(SLOT_MAX));
   assign off_clamp  = off_over ? 10'(SLOT_MAX) : off_ff;
   assign mul_a      = (cur_count > CNT_W'(1)) ? cur_count - CNT_W'(1) : '0;
   assign sum        = SUM_W'(prod_ff) + SUM_W'(off_clamp);
   assign cnt_sat    = (sum > SUM_W'(16'hFFFF)) ? 16'hFFFF : sum[15:0];
   // a link outside the pool ends the chain
   assign head_pop   = (ram_rd_data < SEG_NULL) ? ram_rd_data : SEG_NULL;

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      off_in        = off_ff;
      head_in       = head_ff;
      active_in     = active_ff;
      top_in        = top_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      walk_in       = walk_ff;
      steps_in      = steps_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_seg_in    = res_seg_ff;
      res_off_in    = res_off_ff;
      res_cnt_in    = res_cnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (cmd.act)
         ACT_LOAD: begin
            op_in  = req_tuser;
            id_in  = req_tdata[1:0];
            off_in = req_tdata[11:2];
         end
         ACT_NOTHING: begin
            res_status_in = ST_NOTHING;
            res_seg_in    = '0;
            res_off_in    = '0;
            res_cnt_in    = '0;
         end
         ACT_INACTIVE: begin
            res_status_in = ST_INACTIVE;
            res_seg_in    = '0;
            res_off_in    = '0;
            res_cnt_in    = '0;
         end
         ACT_EMPTY: begin
            res_status_in = ST_EMPTY;
            res_seg_in    = (op_ff == OP_INIT) ? 6'd0 : 6'(cur_top);
            res_off_in    = off_ff;
            res_cnt_in    = '0;
         end
         ACT_RD_HEAD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = head_ff[SEG_W-1:0];
         end
         ACT_RD_TOP: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cur_top;
         end
         ACT_POP: begin
            // head segment becomes the stack's new top
            ram_wr_en   = 1'b1;
            ram_wr_addr = head_ff[SEG_W-1:0];
            ram_wr_data = (op_ff == OP_INIT) ? SEG_NULL : LINK_W'(cur_top);
            head_in     = head_pop;
            top_in[idx] = head_ff[SEG_W-1:0];
            if (op_ff == OP_INIT) begin
               active_in[idx] = 1'b1;
               count_in[idx]  = CNT_W'(1);
            end else if (cur_count < WALK_MAX) begin
               count_in[idx] = cur_count + CNT_W'(1);
            end
            res_status_in = ST_DONE;
            res_seg_in    = 6'(head_ff[SEG_W-1:0]);
            res_off_in    = '0;
            res_cnt_in    = '0;
         end
         ACT_UNLINK: begin
            if (ram_rd_data >= SEG_NULL) begin
               res_status_in = ST_NOTHING;
               res_seg_in    = 6'(cur_top);
               res_off_in    = off_ff;
               res_cnt_in    = '0;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_top;
               ram_wr_data = head_ff;
               head_in     = LINK_W'(cur_top);
               top_in[idx] = ram_rd_data[SEG_W-1:0];
               if (cur_count > CNT_W'(1)) begin
                  count_in[idx] = cur_count - CNT_W'(1);
               end
               res_status_in = ST_DONE;
               res_seg_in    = 6'(ram_rd_data[SEG_W-1:0]);
               res_off_in    = 10'(SLOT_MAX);
               res_cnt_in    = '0;
            end
         end
         ACT_WALK_START: begin
            walk_in  = LINK_W'(cur_top);
            steps_in = '0;
         end
         ACT_WALK_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = walk_ff[SEG_W-1:0];
         end
         ACT_WALK_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = walk_ff[SEG_W-1:0];
            ram_wr_data = head_ff;
            head_in     = walk_ff;
            walk_in     = ram_rd_data;
            steps_in    = steps_ff + CNT_W'(1);
         end
         ACT_WALK_END: begin
            active_in[idx] = 1'b0;
            top_in[idx]    = '0;
            count_in[idx]  = '0;
            res_status_in  = ST_DONE;
            res_seg_in     = '0;
            res_off_in     = '0;
            res_cnt_in     = '0;
         end
         ACT_MUL: begin
            prod_in = PROD_W'(mul_a) * PROD_W'(SLOT_MAX);
         end
         ACT_SIZE: begin
            res_status_in = ST_DONE;
            res_seg_in    = 6'(cur_top);
            res_off_in    = off_clamp;
            res_cnt_in    = cnt_sat;
         end
         ACT_EMIT: begin
            rsp_status_in = res_status_ff;
            rsp_seg_in    = res_seg_ff;
            rsp_off_in    = res_off_ff;
            rsp_cnt_in    = res_cnt_ff;
         end
         ACT_CLEAR: begin
            // chain every segment to the next one
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = LINK_W'(clr_ff) + LINK_W'(1);
            clr_in      = clr_ff + SEG_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (cmd.act == ACT_EMIT) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_STACKS; k++) begin
            active_ff[k] <= 1'b0;
            top_ff[k]    <= '0;
            count_ff[k]  <= '0;
         end
      end else begin
         head_ff      <= head_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      off_ff        <= off_in;
      walk_ff       <= walk_in;
      steps_ff      <= steps_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_seg_ff    <= res_seg_in;
      res_off_ff    <= res_off_in;
      res_cnt_ff    <= res_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign stat.op         = op_ff;
   assign stat.op_ok      = (op_ff <= OP_SIZE);
   assign stat.id_ok      = id_ok;
   assign stat.active     = cur_active;
   assign stat.head_null  = (head_ff >= SEG_NULL);
   assign stat.walk_done  = (walk_ff >= SEG_NULL) || (steps_ff == WALK_MAX);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;
   assign stat.clear_last = (clr_ff == CLR_LAST);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_off_ff, rsp_seg_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- design/ssa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssa_ctrl
// Controller: sequences link clearing, request decode, link memory accesses
// and the free-stack walk, one request at a time.
// ----------------------------------------------------------------------------
module ssa_ctrl import ssa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_POP     = 4'd3;
   localparam logic [3:0] S_UNLINK  = 4'd4;
   localparam logic [3:0] S_WALK_RD = 4'd5;
   localparam logic [3:0] S_WALK_WR = 4'd6;
   localparam logic [3:0] S_SIZE    = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.act  = ACT_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.act = ACT_CLEAR;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.act  = ACT_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            if (!stat.op_ok) begin
               cmd.act = ACT_NOTHING;
            end else if (!stat.id_ok) begin
               cmd.act = ACT_INACTIVE;
            end else begin
               case (stat.op)
                  OP_INIT: begin
                     if (stat.active) begin
                        cmd.act = ACT_INACTIVE;
                     end else if (stat.head_null) begin
                        cmd.act = ACT_EMPTY;
                     end else begin
                        cmd.act  = ACT_RD_HEAD;
                        state_in = S_POP;
                     end
                  end
                  OP_ALLOC: begin
                     if (!stat.active) begin
                        cmd.act = ACT_INACTIVE;
                     end else if (stat.head_null) begin
                        cmd.act = ACT_EMPTY;
                     end else begin
                        cmd.act  = ACT_RD_HEAD;
                        state_in = S_POP;
                     end
                  end
                  OP_FREE_SEG: begin
                     if (!stat.active) begin
                        cmd.act = ACT_INACTIVE;
                     end else begin
                        cmd.act  = ACT_RD_TOP;
                        state_in = S_UNLINK;
                     end
                  end
                  OP_FREE_STK: begin
                     if (!stat.active) begin
                        cmd.act = ACT_INACTIVE;
                     end else begin
                        cmd.act  = ACT_WALK_START;
                        state_in = S_WALK_RD;
                     end
                  end
                  OP_SIZE: begin
                     if (!stat.active) begin
                        cmd.act = ACT_INACTIVE;
                     end else begin
                        cmd.act  = ACT_MUL;
                        state_in = S_SIZE;
                     end
                  end
                  default: begin
                     cmd.act = ACT_NOTHING;
                  end
               endcase
            end
         end
         S_POP: begin
            cmd.act  = ACT_POP;
            state_in = S_RESP;
         end
         S_UNLINK: begin
            cmd.act  = ACT_UNLINK;
            state_in = S_RESP;
         end
         S_WALK_RD: begin
            if (stat.walk_done) begin
               cmd.act  = ACT_WALK_END;
               state_in = S_RESP;
            end else begin
               cmd.act  = ACT_WALK_RD;
               state_in = S_WALK_WR;
            end
         end
         S_WALK_WR: begin
            cmd.act  = ACT_WALK_WR;
            state_in = S_WALK_RD;
         end
         S_SIZE: begin
            cmd.act  = ACT_SIZE;
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the response register is free
            if (stat.out_free) begin
               cmd.act  = ACT_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule
